@@ rtl/smc_pkg.sv @@
// ----------------------------------------------------------------------------
// smc_pkg: shared types, constants and helpers
// Configuration record, register map codes, shift selects and saturating
// Q24.24 helpers for the stepper motion command block.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  localparam int MUL_XW = 96;
  localparam int MUL_YW = 64;
  localparam int MUL_PW = MUL_XW + MUL_YW;

  localparam int DIV_N  = 96;
  localparam int DIV_CW = $clog2(DIV_N + 1);

  localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;
  localparam logic [31:0] SPEED_OFFSET = 32'h8000_0000;
  localparam logic [63:0] LIM_NONE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_WORD = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] LIM_SPD_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LIM_SPD_POS = 64'h0000_0000_7FFF_FFFF;

  localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SAT_LO = 50'sh3_8000_0000_0000;

  typedef enum logic [2:0] {
    REG_POSITION_MODE  = 3'd0,
    REG_MAX_ACCEL      = 3'd1,
    REG_MAX_VEL        = 3'd2,
    REG_POSITION_SCALE = 3'd3,
    REG_PERIOD_SECONDS = 3'd4,
    REG_PERIOD_RECIP   = 3'd5,
    REG_VEL_GAIN       = 3'd6,
    REG_ACC_GAIN       = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    SH_NONE = 3'd0,
    SH_8    = 3'd1,
    SH_15   = 3'd2,
    SH_16   = 3'd3,
    SH_32   = 3'd4,
    SH_33   = 3'd5,
    SH_VEL  = 3'd6,
    SH_ACC  = 3'd7
  } sh_sel_t;

  typedef struct packed {
    logic        position_mode;
    logic [46:0] max_accel;
    logic [46:0] max_vel;
    logic [47:0] position_scale;
    logic [31:0] period_seconds;
    logic [31:0] period_recip;
    logic [47:0] vel_gain;
    logic [47:0] acc_gain;
  } smc_cfg_t;

  function automatic logic signed [49:0] ext50(input logic signed [47:0] v);
    return $signed({{2{v[47]}}, v});
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > SAT_HI) begin
      r = $signed(POS_LIM);
    end else if (v < SAT_LO) begin
      r = $signed(NEG_LIM);
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    logic [47:0] t;
    t = v[47] ? (~v + 48'd1) : v;
    return t;
  endfunction

  function automatic logic [48:0] mag50(input logic signed [49:0] v);
    logic [49:0] t;
    t = v[49] ? (~v + 50'd1) : v;
    return t[48:0];
  endfunction

endpackage

@@ rtl/smc_if.sv @@
// ----------------------------------------------------------------------------
// smc_if: request and result channels
// Valid/ready channels carrying one axis request and one result word set.
// ----------------------------------------------------------------------------
interface smc_in_if;
  logic               valid;
  logic               ready;
  logic               enable;
  logic signed [47:0] position_command;
  logic signed [47:0] speed_command;
  logic signed [47:0] predicted_position;
  logic signed [47:0] predicted_speed;

  modport source (
    output valid, enable, position_command, speed_command,
           predicted_position, predicted_speed,
    input  ready
  );
  modport sink (
    input  valid, enable, position_command, speed_command,
           predicted_position, predicted_speed,
    output ready
  );
endinterface

interface smc_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        speed_target_word;
  logic [31:0]        accel_word;
  logic signed [47:0] applied_accel;

  modport source (
    output valid, speed_target_word, accel_word, applied_accel,
    input  ready
  );
  modport sink (
    input  valid, speed_target_word, accel_word, applied_accel,
    output ready
  );
endinterface

@@ rtl/smc_regs.sv @@
// ----------------------------------------------------------------------------
// smc_regs: configuration register file
// APB-style write/read port for the eight axis configuration registers.
// ----------------------------------------------------------------------------
module smc_regs
  import smc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output smc_cfg_t          cfg
);

  smc_cfg_t cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.position_mode  <= 1'b1;
      cfg_r.max_accel      <= '0;
      cfg_r.max_vel        <= '0;
      cfg_r.position_scale <= 48'd16777216;
      cfg_r.period_seconds <= 32'd4294967;
      cfg_r.period_recip   <= 32'd256000;
      cfg_r.vel_gain       <= '0;
      cfg_r.acc_gain       <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_POSITION_MODE:  cfg_r.position_mode  <= pwdata[0];
        REG_MAX_ACCEL:      cfg_r.max_accel      <= pwdata[46:0];
        REG_MAX_VEL:        cfg_r.max_vel        <= pwdata[46:0];
        REG_POSITION_SCALE: cfg_r.position_scale <= pwdata[47:0];
        REG_PERIOD_SECONDS: cfg_r.period_seconds <= pwdata[31:0];
        REG_PERIOD_RECIP:   cfg_r.period_recip   <= pwdata[31:0];
        REG_VEL_GAIN:       cfg_r.vel_gain       <= pwdata[47:0];
        REG_ACC_GAIN:       cfg_r.acc_gain       <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POSITION_MODE:  prdata = {63'd0, cfg_r.position_mode};
      REG_MAX_ACCEL:      prdata = {17'd0, cfg_r.max_accel};
      REG_MAX_VEL:        prdata = {17'd0, cfg_r.max_vel};
      REG_POSITION_SCALE: prdata = {16'd0, cfg_r.position_scale};
      REG_PERIOD_SECONDS: prdata = {32'd0, cfg_r.period_seconds};
      REG_PERIOD_RECIP:   prdata = {32'd0, cfg_r.period_recip};
      REG_VEL_GAIN:       prdata = {16'd0, cfg_r.vel_gain};
      REG_ACC_GAIN:       prdata = {16'd0, cfg_r.acc_gain};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/smc_mul.sv @@
// ----------------------------------------------------------------------------
// smc_mul: shared wide multiplier
// Forms a 96 x 64 bit product from six 32 x 32 partial products, one per
// cycle, with a register between each multiply and the accumulate.
// ----------------------------------------------------------------------------
module smc_mul
  import smc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_XW-1:0] x,
  input  logic [MUL_YW-1:0] y,
  output logic              busy,
  output logic              done,
  output logic [MUL_PW-1:0] prod
);

  logic [MUL_XW-1:0] x_r;
  logic [MUL_YW-1:0] y_r;
  logic [2:0]        step_r;
  logic              run_r;
  logic              done_r;
  logic              ppv_r;
  logic [63:0]       pp_r;
  logic [1:0]        off_r;
  logic [MUL_PW-1:0] acc_r;
  logic [1:0]        xi;
  logic              yj;
  logic [31:0]       xl;
  logic [31:0]       yl;

  // step k picks x limb k mod 3 and y limb k div 3
  always_comb begin
    case (step_r)
      3'd0:    begin xi = 2'd0; yj = 1'b0; end
      3'd1:    begin xi = 2'd1; yj = 1'b0; end
      3'd2:    begin xi = 2'd2; yj = 1'b0; end
      3'd3:    begin xi = 2'd0; yj = 1'b1; end
      3'd4:    begin xi = 2'd1; yj = 1'b1; end
      3'd5:    begin xi = 2'd2; yj = 1'b1; end
      default: begin xi = 2'd0; yj = 1'b0; end
    endcase
  end

  assign xl = x_r[32*xi +: 32];
  assign yl = y_r[32*yj +: 32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ppv_r  <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        ppv_r  <= 1'b0;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r != 3'd6) begin
          ppv_r  <= 1'b1;
          step_r <= step_r + 3'd1;
        end else begin
          ppv_r  <= 1'b0;
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else begin
      if (run_r && step_r != 3'd6) begin
        pp_r  <= xl * yl;
        off_r <= xi + {1'b0, yj};
      end
      if (ppv_r) begin
        acc_r <= acc_r + ({{(MUL_PW-64){1'b0}}, pp_r} << {off_r, 5'd0});
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ rtl/smc_div.sv @@
// ----------------------------------------------------------------------------
// smc_div: restoring divider
// One quotient bit per cycle; the quotient saturates at a given limit.
// ----------------------------------------------------------------------------
module smc_div
  import smc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_N-1:0] dividend,
  input  logic [47:0]      divisor,
  input  logic [47:0]      lim,
  output logic             busy,
  output logic             done,
  output logic [47:0]      quot
);

  logic [DIV_N-1:0]  n_r;
  logic [47:0]       d_r;
  logic [47:0]       lim_r;
  logic [48:0]       rem_r;
  logic [47:0]       q_r;
  logic              sat_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [48:0]       rem_sh;
  logic              qbit;
  logic [48:0]       q_sh;

  assign rem_sh = {rem_r[47:0], n_r[DIV_N-1]};
  assign qbit   = rem_sh >= {1'b0, d_r};
  assign q_sh   = {q_r, qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == DIV_CW'(DIV_N - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      d_r   <= divisor;
      lim_r <= lim;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (run_r) begin
      n_r   <= {n_r[DIV_N-2:0], 1'b0};
      rem_r <= qbit ? (rem_sh - {1'b0, d_r}) : rem_sh;
      // hold the limit once the quotient passes it
      if (!sat_r) begin
        if (q_sh > {1'b0, lim_r}) begin
          sat_r <= 1'b1;
        end else begin
          q_r <= q_sh[47:0];
        end
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign quot = sat_r ? lim_r : q_r;

endmodule

@@ rtl/stepgen_motion_command_top.sv @@
// ----------------------------------------------------------------------------
// stepgen_motion_command_top: stepper axis motion command
// Turns one servo-period request into a step rate word and an acceleration
// word, using one shared multiplier and one divider under a sequencer.
// ----------------------------------------------------------------------------
// One request is worked on at a time; ready is high only while the sequencer
// is idle. Every product goes through the shared multiplier as six 32x32
// partial products. A disabled request only clamps and scales the speed;
// a speed-mode request first forms the acceleration word; a position-mode
// request first runs the error products and, when it applies, the
// opposite-sign error correction with its 96-step divide. The result waits
// in an output register, so the next request is taken while it is unread.
module stepgen_motion_command_top
  import smc_pkg::*;
#(
  parameter int VEL_FRACTION_BITS = 40,
  parameter int ACC_FRACTION_BITS = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  smc_in_if.sink            in_ch,
  smc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int VEL_SHIFT = 120 - VEL_FRACTION_BITS;
  localparam int ACC_SHIFT = 128 - ACC_FRACTION_BITS;

  typedef enum logic [26:0] {
    ST_IDLE = 27'h0000001,
    ST_WAIT = 27'h0000002,
    ST_SAT  = 27'h0000004,
    ST_RR   = 27'h0000008,
    ST_P1   = 27'h0000010,
    ST_P2   = 27'h0000020,
    ST_P3   = 27'h0000040,
    ST_P4   = 27'h0000080,
    ST_P5   = 27'h0000100,
    ST_P6   = 27'h0000200,
    ST_P7   = 27'h0000400,
    ST_P8   = 27'h0000800,
    ST_P9   = 27'h0001000,
    ST_P10  = 27'h0002000,
    ST_P11  = 27'h0004000,
    ST_B1   = 27'h0008000,
    ST_B2   = 27'h0010000,
    ST_B3   = 27'h0020000,
    ST_AW1  = 27'h0040000,
    ST_AW2  = 27'h0080000,
    ST_AW3  = 27'h0100000,
    ST_SP1  = 27'h0200000,
    ST_SP2  = 27'h0400000,
    ST_VSAT = 27'h0800000,
    ST_V1   = 27'h1000000,
    ST_V2   = 27'h2000000,
    ST_V3   = 27'h4000000
  } state_t;

  smc_cfg_t cfg;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic in_acc, in_ready, out_load;

  logic               mul_start, mul_busy, mul_done;
  logic [MUL_XW-1:0]  mul_x;
  logic [MUL_YW-1:0]  mul_y;
  logic [MUL_PW-1:0]  mul_prod;
  sh_sel_t            iss_sh, sh_r;
  logic [63:0]        iss_lim, lim_r;
  logic               iss_neg, neg_r;

  logic               div_start, div_busy, div_done;
  logic [47:0]        div_q;

  logic signed [47:0] pos_r, ppos_r, pspd_r;
  logic signed [47:0] last_pos_r, last_vel_r;
  logic [63:0]        rr_r, res_r;
  logic signed [47:0] est_r, acc1_r, vcmd_r, es_r, ee_r, t1_r, acc2_r;
  logic signed [47:0] a_r, speed_r, applied_r;
  logic [31:0]        aword_r;
  logic [31:0]        out_speed_r, out_aword_r;
  logic signed [47:0] out_applied_r;

  logic signed [47:0] res48, scale, a_sum, a_clamp, mx_acc, mx_vel, spd_clamp;
  logic [47:0]        scale_mag;
  logic signed [49:0] v_plus_p, v_minus_p;
  logic               spd_neg, boost_hit;
  logic [MUL_PW-1:0]  shifted;
  logic [63:0]        sat_mag;

  smc_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  smc_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .x    (mul_x),
    .y    (mul_y),
    .busy (mul_busy),
    .done (mul_done),
    .prod (mul_prod)
  );

  smc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(mul_prod[DIV_N-1:0]),
    .divisor (mag48(es_r)),
    .lim     (acc2_r[47] ? NEG_LIM : POS_LIM),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_q)
  );

  assign in_ready     = state_r == ST_IDLE;
  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign out_load     = (state_r == ST_V3) && (!out_valid_r || out_ch.ready);

  assign res48     = res_r[47:0];
  assign scale     = $signed(cfg.position_scale);
  assign scale_mag = mag48(scale);
  assign v_plus_p  = ext50(vcmd_r) + ext50(pspd_r);
  assign v_minus_p = ext50(last_vel_r) - ext50(pspd_r);
  assign spd_neg   = speed_r[47] != scale[47];
  assign mx_acc    = $signed({1'b0, cfg.max_accel});
  assign mx_vel    = $signed({1'b0, cfg.max_vel});
  assign a_sum     = sat48(ext50(acc1_r) + ext50(acc2_r));
  assign boost_hit = (acc1_r == '0) &&
                     ((es_r < 0 && ee_r > 0) || (es_r > 0 && ee_r < 0));

  always_comb begin
    a_clamp = a_sum;
    if (cfg.max_accel != '0) begin
      if (a_sum > mx_acc) begin
        a_clamp = mx_acc;
      end else if (a_sum < -mx_acc) begin
        a_clamp = -mx_acc;
      end
    end
    spd_clamp = speed_r;
    if (speed_r > mx_vel) begin
      spd_clamp = mx_vel;
    end else if (speed_r < -mx_vel) begin
      spd_clamp = -mx_vel;
    end
  end

  // saturating shift of the finished product
  always_comb begin
    case (sh_r)
      SH_NONE: shifted = mul_prod;
      SH_8:    shifted = mul_prod >> 8;
      SH_15:   shifted = mul_prod >> 15;
      SH_16:   shifted = mul_prod >> 16;
      SH_32:   shifted = mul_prod >> 32;
      SH_33:   shifted = mul_prod >> 33;
      SH_VEL:  shifted = mul_prod >> VEL_SHIFT;
      SH_ACC:  shifted = mul_prod >> ACC_SHIFT;
      default: shifted = mul_prod;
    endcase
    if ((|shifted[MUL_PW-1:64]) || (shifted[63:0] > lim_r)) begin
      sat_mag = lim_r;
    end else begin
      sat_mag = shifted[63:0];
    end
  end

  // sequencer: issue at most one product per step, collect via ST_SAT or divider
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r;
    mul_start     = 1'b0;
    mul_x         = '0;
    mul_y         = '0;
    iss_sh        = SH_NONE;
    iss_lim       = LIM_NONE;
    iss_neg       = 1'b0;
    div_start     = 1'b0;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_ch.enable) begin
            state_nxt = ST_VSAT;
          end else if (cfg.position_mode) begin
            state_nxt = ST_RR;
          end else begin
            state_nxt = ST_AW1;
          end
        end
      end
      ST_WAIT: begin
        if (mul_done) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        state_nxt = ret_r;
      end
      ST_RR: begin
        mul_start = 1'b1;
        mul_x     = {64'd0, cfg.period_recip};
        mul_y     = {32'd0, cfg.period_recip};
        ret_nxt   = ST_P1;
        state_nxt = ST_WAIT;
      end
      ST_P1: begin
        mul_start = 1'b1;
        mul_x     = {48'd0, mag48(last_vel_r)};
        mul_y     = {32'd0, cfg.period_seconds};
        iss_sh    = SH_32;
        iss_neg   = last_vel_r[47];
        iss_lim   = {16'd0, iss_neg ? NEG_LIM : POS_LIM};
        ret_nxt   = ST_P2;
        state_nxt = ST_WAIT;
      end
      ST_P2: begin
        state_nxt = ST_P3;
      end
      ST_P3: begin
        mul_start = 1'b1;
        mul_x     = {48'd0, mag48(est_r)};
        mul_y     = rr_r;
        iss_sh    = SH_15;
        iss_neg   = est_r[47];
        iss_lim   = {16'd0, iss_neg ? NEG_LIM : POS_LIM};
        ret_nxt   = ST_P4;
        state_nxt = ST_WAIT;
      end
      ST_P4: begin
        mul_start = 1'b1;
        mul_x     = {48'd0, mag48(res48)};
        mul_y     = {32'd0, cfg.period_seconds};
        iss_sh    = SH_32;
        iss_neg   = res48[47];
        iss_lim   = {16'd0, iss_neg ? NEG_LIM : POS_LIM};
        ret_nxt   = ST_P5;
        state_nxt = ST_WAIT;
      end
      ST_P5: begin
        state_nxt = ST_P6;
      end
      ST_P6: begin
        mul_start = 1'b1;
        mul_x     = {47'd0, mag50(v_plus_p)};
        mul_y     = {32'd0, cfg.period_seconds};
        iss_sh    = SH_33;
        iss_neg   = v_plus_p[49];
        iss_lim   = {16'd0, iss_neg ? NEG_LIM : POS_LIM};
        ret_nxt   = ST_P7;
        state_nxt = ST_WAIT;
      end
      ST_P7: begin
        state_nxt = ST_P8;
      end
      ST_P8: begin
        mul_start = 1'b1;
        mul_x     = {47'd0, mag50(v_minus_p)};
        mul_y     = {32'd0, cfg.period_recip};
        iss_sh    = SH_8;
        iss_neg   = v_minus_p[49];
        iss_lim   = {16'd0, iss_neg ? NEG_LIM : POS_LIM};
        ret_nxt   = ST_P9;
        state_nxt = ST_WAIT;
      end
      ST_P9: begin
        mul_start = 1'b1;
        mul_x     = {48'd0, mag48(ee_r)};
        mul_y     = rr_r;
        iss_sh    = SH_16;
        iss_neg   = ee_r[47];
        iss_lim   = {16'd0, iss_neg ? NEG_LIM : POS_LIM};
        ret_nxt   = ST_P10;
        state_nxt = ST_WAIT;
      end
      ST_P10: begin
        state_nxt = boost_hit ? ST_B1 : ST_P11;
      end
      ST_B1: begin
        mul_start = 1'b1;
        mul_x     = {48'd0, mag48(acc2_r)};
        mul_y     = {15'd0, {1'b0, mag48(es_r)} + {1'b0, mag48(ee_r)}};
        state_nxt = ST_B2;
      end
      ST_B2: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = ST_B3;
        end
      end
      ST_B3: begin
        if (div_done) begin
          state_nxt = ST_P11;
        end
      end
      ST_P11: begin
        state_nxt = ST_AW1;
      end
      ST_AW1: begin
        mul_start = 1'b1;
        mul_x     = cfg.position_mode ? {48'd0, mag48(a_r)} : {49'd0, cfg.max_accel};
        mul_y     = {16'd0, scale_mag};
        ret_nxt   = ST_AW2;
        state_nxt = ST_WAIT;
      end
      ST_AW2: begin
        mul_start = 1'b1;
        mul_x     = mul_prod[MUL_XW-1:0];
        mul_y     = {16'd0, cfg.acc_gain};
        iss_sh    = SH_ACC;
        iss_lim   = LIM_WORD;
        ret_nxt   = ST_AW3;
        state_nxt = ST_WAIT;
      end
      ST_AW3: begin
        state_nxt = cfg.position_mode ? ST_SP1 : ST_VSAT;
      end
      ST_SP1: begin
        mul_start = 1'b1;
        mul_x     = {48'd0, mag48(a_r)};
        mul_y     = {32'd0, cfg.period_seconds};
        iss_sh    = (aword_r == '0) ? SH_33 : SH_32;
        iss_neg   = a_r[47];
        iss_lim   = {16'd0, iss_neg ? NEG_LIM : POS_LIM};
        ret_nxt   = ST_SP2;
        state_nxt = ST_WAIT;
      end
      ST_SP2: begin
        state_nxt = ST_VSAT;
      end
      ST_VSAT: begin
        state_nxt = ST_V1;
      end
      ST_V1: begin
        mul_start = 1'b1;
        mul_x     = {48'd0, mag48(speed_r)};
        mul_y     = {16'd0, scale_mag};
        ret_nxt   = ST_V2;
        state_nxt = ST_WAIT;
      end
      ST_V2: begin
        mul_start = 1'b1;
        mul_x     = mul_prod[MUL_XW-1:0];
        mul_y     = {16'd0, cfg.vel_gain};
        iss_sh    = SH_VEL;
        iss_neg   = spd_neg;
        iss_lim   = spd_neg ? LIM_SPD_NEG : LIM_SPD_POS;
        ret_nxt   = ST_V3;
        state_nxt = ST_WAIT;
      end
      ST_V3: begin
        // hold until the output register frees up
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_pos_r  <= '0;
      last_vel_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_P10) begin
        last_vel_r <= vcmd_r;
        last_pos_r <= pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      sh_r  <= iss_sh;
      lim_r <= iss_lim;
      neg_r <= iss_neg;
    end
    if (out_load) begin
      out_speed_r   <= SPEED_OFFSET + res_r[31:0];
      out_aword_r   <= aword_r;
      out_applied_r <= applied_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_r     <= in_ch.position_command;
          ppos_r    <= in_ch.predicted_position;
          pspd_r    <= in_ch.predicted_speed;
          aword_r   <= '0;
          applied_r <= '0;
          speed_r   <= '0;
          if (in_ch.enable && !cfg.position_mode) begin
            speed_r   <= in_ch.speed_command;
            applied_r <= mx_acc;
          end
        end
      end
      ST_SAT: begin
        res_r <= neg_r ? (~sat_mag + 64'd1) : sat_mag;
      end
      ST_P1: begin
        rr_r <= res_r;
      end
      ST_P2: begin
        est_r <= sat48(ext50(pos_r) - ext50(sat48(ext50(last_pos_r) + ext50(res48))));
      end
      ST_P4: begin
        acc1_r <= res48;
      end
      ST_P5: begin
        vcmd_r <= sat48(ext50(last_vel_r) + ext50(res48));
        es_r   <= sat48(ext50(last_pos_r) - ext50(ppos_r));
      end
      ST_P7: begin
        ee_r <= sat48(ext50(pos_r) - ext50(sat48(ext50(ppos_r) + ext50(res48))));
      end
      ST_P9: begin
        t1_r <= res48;
      end
      ST_P10: begin
        acc2_r <= sat48(ext50(t1_r) + ext50(res48));
      end
      ST_B3: begin
        if (div_done) begin
          acc2_r <= acc2_r[47] ? $signed(~div_q + 48'd1) : $signed(div_q);
        end
      end
      ST_P11: begin
        a_r       <= a_clamp;
        applied_r <= a_clamp;
      end
      ST_AW3: begin
        aword_r <= res_r[31:0];
      end
      ST_SP2: begin
        speed_r <= sat48(ext50(pspd_r) + ext50(res48));
      end
      ST_VSAT: begin
        speed_r <= spd_clamp;
      end
      default: ;
    endcase
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.speed_target_word = out_speed_r;
  assign out_ch.accel_word        = out_aword_r;
  assign out_ch.applied_accel     = out_applied_r;

`ifndef SYNTH
  a_mul_no_reissue: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mul_busy && !div_busy)
    else $error("arithmetic unit running while sequencer idle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_V3))
    else $error("result raised outside final step");
`endif

endmodule
